/* hw/rtl/ttt_pkg.sv */
// Package for the thermistor table temperature block: widths, constants, resistance ROM.
// No dependencies.
package ttt_pkg;
  localparam int TableEntries = 76;
  localparam int Channels = 6;
  localparam int IdxW = 7;
  localparam int ChW = 3;
  localparam logic [15:0] ShortMaxCode = 16'd9;
  localparam logic [15:0] OpenMinCode = 16'd32759;
  localparam logic signed [15:0] TempShort = 16'sd32000;
  localparam logic signed [15:0] TempOpen = -16'sd10240;
  localparam logic signed [15:0] TempCapLow = 16'sd2560;
  localparam logic signed [15:0] TempCapHigh = 16'sd21760;
  localparam logic signed [17:0] TempMin = -18'sd10240;
  localparam logic signed [17:0] TempMax = 18'sd32000;

  localparam logic [2:0] StInterp = 3'd0;
  localparam logic [2:0] StShort = 3'd1;
  localparam logic [2:0] StOpen = 3'd2;
  localparam logic [2:0] StCapLow = 3'd3;
  localparam logic [2:0] StCapHigh = 3'd4;

  localparam logic [1:0] RegSeries = 2'd0;
  localparam logic [1:0] RegOffset = 2'd1;
  localparam logic [1:0] RegFormat = 2'd2;

  typedef struct packed {
    logic [2:0] channel;
    logic signed [16:0] signed_code;
    logic signed [15:0] instant_temp;
    logic signed [15:0] filtered_temp;
    logic [2:0] range_status;
  } result_t;

  function automatic logic [15:0] res_rom(input logic [IdxW-1:0] i);
    logic [15:0] r;
    case (i)
      7'd0: r = 18787; 7'd1: r = 17983; 7'd2: r = 17219; 7'd3: r = 16490;
      7'd4: r = 15797; 7'd5: r = 15136; 7'd6: r = 14506; 7'd7: r = 13906;
      7'd8: r = 13334; 7'd9: r = 12788; 7'd10: r = 12268; 7'd11: r = 11771;
      7'd12: r = 11297; 7'd13: r = 10845; 7'd14: r = 10413; 7'd15: r = 10000;
      7'd16: r = 9606; 7'd17: r = 9229; 7'd18: r = 8869; 7'd19: r = 8525;
      7'd20: r = 8196; 7'd21: r = 7882; 7'd22: r = 7581; 7'd23: r = 7293;
      7'd24: r = 7018; 7'd25: r = 6754; 7'd26: r = 6501; 7'd27: r = 6260;
      7'd28: r = 6028; 7'd29: r = 5806; 7'd30: r = 5594; 7'd31: r = 5390;
      7'd32: r = 5195; 7'd33: r = 5007; 7'd34: r = 4828; 7'd35: r = 4656;
      7'd36: r = 4490; 7'd37: r = 4332; 7'd38: r = 4180; 7'd39: r = 4034;
      7'd40: r = 3893; 7'd41: r = 3759; 7'd42: r = 3629; 7'd43: r = 3505;
      7'd44: r = 3386; 7'd45: r = 3271; 7'd46: r = 3160; 7'd47: r = 3054;
      7'd48: r = 2952; 7'd49: r = 2854; 7'd50: r = 2760; 7'd51: r = 2669;
      7'd52: r = 2582; 7'd53: r = 2498; 7'd54: r = 2417; 7'd55: r = 2339;
      7'd56: r = 2264; 7'd57: r = 2191; 7'd58: r = 2122; 7'd59: r = 2055;
      7'd60: r = 1990; 7'd61: r = 1928; 7'd62: r = 1868; 7'd63: r = 1810;
      7'd64: r = 1754; 7'd65: r = 1700; 7'd66: r = 1648; 7'd67: r = 1598;
      7'd68: r = 1550; 7'd69: r = 1503; 7'd70: r = 1458; 7'd71: r = 1414;
      7'd72: r = 1372; 7'd73: r = 1332; 7'd74: r = 1293; 7'd75: r = 1255;
      default: r = 16'd0;
    endcase
    return r;
  endfunction
endpackage

/* hw/rtl/ttt_divider.sv */
// Restoring divider, one quotient bit per cycle: 40-bit dividend by 32-bit divisor, 9-bit quotient.
// No package dependencies; standalone.
module ttt_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [8:0]  quotient
);
  logic [39:0] rem;
  logic [31:0] dsr;
  logic [3:0]  cnt;
  logic        busy;
  logic [40:0] trial;

  // quotient fits 9 bits (frac <= 256), so start shifted by 8
  assign trial = {1'b0, rem} - ({9'd0, dsr} << cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == 4'd0);
      if (start) begin
        busy <= 1'b1;
        rem <= dividend;
        dsr <= divisor;
        cnt <= 4'd8;
        quotient <= '0;
      end else if (busy) begin
        if (!trial[40]) begin
          rem <= trial[39:0];
          quotient[cnt] <= 1'b1;
        end
        if (cnt == 4'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end
endmodule

/* hw/rtl/ttt_avg_store.sv */
// Per-channel moving-average memory with synchronous (registered) read.
// Depends on ttt_pkg.
module ttt_avg_store (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ttt_pkg::ChW-1:0]  rd_addr,
  output logic signed [15:0]       rd_data,
  input  logic                     wr_en,
  input  logic [ttt_pkg::ChW-1:0]  wr_addr,
  input  logic signed [15:0]       wr_data
);
  logic signed [15:0] mem [ttt_pkg::Channels];
  logic [ttt_pkg::Channels-1:0] valid;
  logic signed [15:0] q;
  logic v;

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (wr_en) valid[wr_addr] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    q <= mem[rd_addr];
    v <= valid[rd_addr];
  end
  // unwritten entries read as reset value zero
  assign rd_data = v ? q : 16'sd0;
endmodule

/* hw/rtl/thermistor_table_temperature_top.sv */
// Top level of the thermistor table temperature block: sequencer, search, EMA.
// Depends on ttt_pkg, ttt_divider, ttt_avg_store.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata: raw_channel[3:0] sign_nibble[7:4] sample_code[23:8]
// m_axis    out  tvalid/tready        tdata: channel, signed_code, instant, filtered, status
// cfg       in   cfg_we               cfg_index selects register, cfg_data value
//
// One item at a time. An interpolated reading passes from its transfer to the next tready
// through capture, multiply, range checks, binary search (six or seven probes, one exit),
// bracket products, divider, temperature, average update and hand-off. Shorts and opens
// go from the multiply step to the average update, caps from the range checks. Dropped
// items return straight to idle. Reset clears control and average valid bits and loads
// config defaults. While a result waits in the output register, the next item is accepted.
module thermistor_table_temperature_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // raw_channel, sign_nibble, sample_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // channel[2:0], signed_code[19:3], instant_temp[35:20],
                                      // filtered_temp[51:36], range_status[54:52]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_RANGE = 10'b0000000100,
    S_SRCH  = 10'b0000001000,
    S_SCMP  = 10'b0000010000,
    S_IMUL  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_TEMP  = 10'b0010000000,
    S_EMA   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  localparam int IW = ttt_pkg::IdxW;

  state_t state;
  logic [16:0] series_resistance;
  logic signed [12:0] temp_offset;
  logic channel_id_format;

  logic [2:0] ch;
  logic signed [16:0] code;
  logic [31:0] num;        // rs * code, < 2^32
  logic [15:0] den;
  logic [IW-1:0] lo, hi;
  logic [31:0] prod;       // registered ROM * den
  logic [1:0]  phase;
  logic [31:0] lo_v;
  logic [2:0]  st;
  logic signed [17:0] tsum;
  logic signed [15:0] t;
  logic signed [15:0] tbase;
  logic div_start, div_done;
  logic [8:0] frac;
  logic [39:0] dvd;
  logic [31:0] dsr;
  logic signed [15:0] avg_rd;
  logic signed [15:0] avg_new;
  logic avg_we;
  logic signed [21:0] ema_s;
  logic [41:0] ema_q;
  ttt_pkg::result_t res;
  logic out_full;
  logic out_load;

  logic [IW-1:0] mid;
  logic [IW-1:0] rom_idx;
  assign mid = IW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      series_resistance <= 17'd10000;
      temp_offset <= -13'sd435;
      channel_id_format <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ttt_pkg::RegSeries: series_resistance <= cfg_data;
        ttt_pkg::RegOffset: temp_offset <= cfg_data[12:0];
        ttt_pkg::RegFormat: channel_id_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = {1'b0, res.range_status, res.filtered_temp, res.instant_temp,
                         res.signed_code, res.channel};

  // result register loads when the average step finds it free or draining
  assign out_load = (state == S_EMA) && (!out_full || m_axis_tready);

  ttt_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd), .divisor(dsr),
    .done(div_done), .quotient(frac)
  );

  ttt_avg_store u_avg (
    .clk(clk), .rst(rst), .rd_addr(ch), .rd_data(avg_rd),
    .wr_en(avg_we), .wr_addr(ch), .wr_data(avg_new)
  );

  always_comb begin
    tsum = 18'(tbase) + 18'(temp_offset);
    if (tsum < ttt_pkg::TempMin) t = ttt_pkg::TempMin[15:0];
    else if (tsum > ttt_pkg::TempMax) t = ttt_pkg::TempMax[15:0];
    else t = tsum[15:0];
  end

  // floor(s/10) for 0 <= s < 2^21 by reciprocal 838861/2^23 (exact below 2^22)
  assign ema_s = 22'sd9 * 22'(avg_rd) + 22'(t) + 22'sd655365;
  assign ema_q = (42'(ema_s[20:0]) * 42'd838861) >> 23;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      div_start <= 1'b0;
      avg_we <= 1'b0;
    end else begin
      div_start <= (state == S_IMUL) && (phase != 2'd0) && (lo_v != prod);
      avg_we <= out_load;
      if (out_load) out_full <= 1'b1;
      else if (m_axis_tready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            ch <= 3'(s_axis_tdata[3:0] ^ 4'd1);
            if (s_axis_tdata[7:4] == 4'hF && s_axis_tdata[23])
              code <= {1'b1, s_axis_tdata[23:8]};
            else
              code <= {1'b0, s_axis_tdata[23:8]};
            if (channel_id_format && s_axis_tdata[3:0] < 4'(ttt_pkg::Channels) &&
                (s_axis_tdata[3:0] ^ 4'd1) < 4'(ttt_pkg::Channels))
              state <= S_MUL;
          end
        end
        S_MUL: begin
          num <= 32'(series_resistance) * 32'(code[15:0]);
          den <= 16'(17'sd32768 - code);
          lo <= '0;
          hi <= IW'(ttt_pkg::TableEntries - 1);
          phase <= 2'd0;
          if (code <= $signed({1'b0, ttt_pkg::ShortMaxCode})) begin
            st <= ttt_pkg::StShort; tbase <= ttt_pkg::TempShort; state <= S_EMA;
          end else if (code >= $signed({1'b0, ttt_pkg::OpenMinCode})) begin
            st <= ttt_pkg::StOpen; tbase <= ttt_pkg::TempOpen; state <= S_EMA;
          end else begin
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          // phase 0: ROM[0]*den, 1: check, ROM[last]*den, 2: check
          prod <= 32'(ttt_pkg::res_rom(rom_idx)) * 32'(den);
          phase <= phase + 2'd1;
          if (phase == 2'd1 && num >= prod) begin
            st <= ttt_pkg::StCapLow; tbase <= ttt_pkg::TempCapLow; state <= S_EMA;
          end else if (phase == 2'd2) begin
            if (num <= prod) begin
              st <= ttt_pkg::StCapHigh; tbase <= ttt_pkg::TempCapHigh; state <= S_EMA;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (hi - lo > IW'(1)) begin
            prod <= 32'(ttt_pkg::res_rom(mid)) * 32'(den);
            state <= S_SCMP;
          end else begin
            prod <= 32'(ttt_pkg::res_rom(lo)) * 32'(den);
            phase <= 2'd0;
            state <= S_IMUL;
          end
        end
        S_SCMP: begin
          if (num < prod) lo <= mid;
          else hi <= mid;
          state <= S_SRCH;
        end
        S_IMUL: begin
          phase <= phase + 2'd1;
          if (phase == 2'd0) begin
            lo_v <= prod;
            prod <= 32'(ttt_pkg::res_rom(hi)) * 32'(den);
          end else begin
            dvd <= {lo_v - num, 8'd0};
            dsr <= lo_v - prod;
            if (lo_v == prod) begin
              st <= ttt_pkg::StInterp;
              tbase <= 16'((32'(lo) + 32'd10) << 8);
              state <= S_EMA;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            st <= ttt_pkg::StInterp;
            tbase <= 16'(((32'(lo) + 32'd10) << 8) + 32'(frac));
            state <= S_TEMP;
          end
        end
        S_TEMP: state <= S_EMA;
        S_EMA: begin
          // avg_rd is valid: read address ch held since capture
          if (out_load) begin
            avg_new <= (avg_rd == 16'sd0) ? t : 16'(ema_q - 42'd65536);
            res.channel <= ch;
            res.signed_code <= code;
            res.instant_temp <= t;
            res.filtered_temp <= (avg_rd == 16'sd0) ? t : 16'(ema_q - 42'd65536);
            res.range_status <= st;
            state <= S_OUT;
          end
        end
        S_OUT: state <= S_IDLE;  // lets the store write land before the next read
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    case (phase)
      2'd0: rom_idx = '0;
      default: rom_idx = IW'(ttt_pkg::TableEntries - 1);
    endcase
  end
endmodule

/* test/thermistor_table_temperature_top_test.sv */
// Testbench for thermistor_table_temperature_top: directed and random ADC words,
// predicted temperatures and channel averages checked field by field. Depends on ttt_pkg.
module thermistor_table_temperature_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // raw_channel[3:0], sign_nibble[7:4], sample_code[23:8]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // channel, signed_code, instant_temp, filtered_temp,
                                    // range_status, zero fill
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = ttt_pkg::RegSeries;
  logic [16:0] cfg_data = '0;

  thermistor_table_temperature_top DUT (.*);

  always #1 clk = ~clk;

  // Predictor state: register copies and per-channel averages.
  int unsigned pullup_ohms;
  int          cal_offset;
  bit          id_format;
  int          ema_store [ttt_pkg::Channels];
  int unsigned rom_ohms [ttt_pkg::TableEntries];

  ttt_pkg::result_t expected_results [$];
  bit          failed;
  longint      cycle_count;
  int          stall_mode;

  localparam longint CycleLimit = 64'd1_000_000;

  // Table temperature in Q8.8, no offset; status through st.
  function automatic int lookup_temp(int code, int unsigned rs, output logic [2:0] st);
    longint unsigned num, den, lo_v, hi_v, step, frac;
    int lo, hi, mid;
    if (code <= 9) begin st = ttt_pkg::StShort; return 32000; end
    if (code >= 32759) begin st = ttt_pkg::StOpen; return -10240; end
    num = longint'(rs) * longint'(code);
    den = longint'(32768 - code);
    if (num >= rom_ohms[0] * den) begin st = ttt_pkg::StCapLow; return 2560; end
    if (num <= rom_ohms[ttt_pkg::TableEntries-1] * den) begin
      st = ttt_pkg::StCapHigh;
      return 21760;
    end
    lo = 0;
    hi = ttt_pkg::TableEntries - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (num < rom_ohms[mid] * den) lo = mid;
      else hi = mid;
    end
    lo_v = rom_ohms[lo] * den;
    hi_v = rom_ohms[hi] * den;
    step = lo_v - hi_v;
    frac = (step != 0) ? ((lo_v - num) * 256) / step : 0;
    st = ttt_pkg::StInterp;
    return (10 + lo) * 256 + int'(frac);
  endfunction

  // Updates averages and queues the expected result, if any.
  function automatic void predict_reading(logic [3:0] raw_ch, logic [3:0] sgn,
                                          logic [15:0] ucode);
    ttt_pkg::result_t r;
    int ch, code, t, avg;
    logic [2:0] st;
    if (!id_format || raw_ch >= ttt_pkg::Channels) return;
    ch = raw_ch ^ 1;
    if (ch >= ttt_pkg::Channels) return;
    code = (sgn == 4'hF && ucode[15]) ? int'(ucode) - 65536 : int'(ucode);
    t = lookup_temp(code, pullup_ohms, st) + cal_offset;
    if (t < -10240) t = -10240;
    if (t > 32000) t = 32000;
    avg = ema_store[ch];
    if (avg == 0) avg = t;
    else avg = (9 * avg + t + 5 + 655360) / 10 - 65536;
    ema_store[ch] = avg;
    r.channel = ch[2:0];
    r.signed_code = code[16:0];
    r.instant_temp = t[15:0];
    r.filtered_temp = avg[15:0];
    r.range_status = st;
    expected_results.push_back(r);
  endfunction

  // One ADC word transfer; tvalid stays high into the next word unless a gap is drawn.
  task automatic send_reading(logic [3:0] raw_ch, logic [3:0] sgn, logic [15:0] ucode);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ucode, sgn, raw_ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_reading(raw_ch, sgn, ucode);
  endtask

  // Waits for the block to drain, then writes a register and its model copy.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ttt_pkg::RegSeries: pullup_ohms = 32'(val);
      ttt_pkg::RegOffset: cal_offset = val[12] ? int'(val[12:0]) - 8192 : int'(val[12:0]);
      ttt_pkg::RegFormat: id_format = val[0];
      default: ;
    endcase
  endtask

  // Code giving a divider resistance near r ohms under the current pull-up.
  function automatic logic [15:0] code_for_ohms(int unsigned r);
    longint unsigned c;
    c = (longint'(r) * 32768) / (longint'(pullup_ohms) + r);
    return c[15:0];
  endfunction

  task automatic test_fault_and_caps;
    send_reading(4'd0, 4'h0, 16'd0);
    send_reading(4'd1, 4'h0, 16'd9);
    send_reading(4'd2, 4'h0, 16'd10);
    send_reading(4'd3, 4'hF, 16'hFFFF);        // negative code: short
    send_reading(4'd4, 4'hF, 16'h8000);
    send_reading(4'd5, 4'h0, 16'd32758);
    send_reading(4'd0, 4'h0, 16'd32759);       // open
    send_reading(4'd1, 4'h0, 16'hFFFF);        // above full scale
    send_reading(4'd2, 4'h7, 16'h8000);        // sign nibble not all ones
    send_reading(4'd3, 4'h0, 16'd20000);       // interpolated near the low end
    send_reading(4'd4, 4'h0, 16'd2000);        // capped high
    send_reading(4'd5, 4'h0, 16'd16384);       // mid table
  endtask

  task automatic test_dropped_channels;
    for (int c = 6; c < 16; c++) send_reading(c[3:0], 4'h0, 16'd12000);
    send_reading(4'd4, 4'h0, 16'd12000);       // swapped to 5
  endtask

  task automatic test_table_points;
    // codes near every fifth ROM entry, and the next code up
    for (int i = 0; i < ttt_pkg::TableEntries; i += 5) begin
      send_reading(4'($urandom_range(0, 5)), 4'h0, code_for_ohms(rom_ohms[i]));
      send_reading(4'($urandom_range(0, 5)), 4'h0, 16'(code_for_ohms(rom_ohms[i]) + 16'd1));
    end
  endtask

  task automatic random_phase(int count);
    logic [3:0] ch, sgn;
    logic [15:0] code;
    for (int n = 0; n < count; n++) begin
      ch = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
      sgn = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h0;
      case ($urandom_range(0, 5))
        0: code = 16'($urandom);
        1: code = 16'($urandom_range(0, 20));
        2: code = 16'($urandom_range(32740, 32800));
        default: code = code_for_ohms($urandom_range(1100, 20000));
      endcase
      send_reading(ch, sgn, code);
    end
  endtask

  task automatic test_register_sweep;
    write_reg(ttt_pkg::RegSeries, 17'd1000);
    write_reg(ttt_pkg::RegOffset, 17'(-2560));
    random_phase(250);
    write_reg(ttt_pkg::RegSeries, 17'd100000);
    write_reg(ttt_pkg::RegOffset, 17'd2560);
    random_phase(250);
    write_reg(ttt_pkg::RegSeries, 17'd0);      // zero pull-up caps high
    send_reading(4'd0, 4'h0, 16'd5000);
    write_reg(ttt_pkg::RegSeries, 17'h1FFFF);
    write_reg(ttt_pkg::RegOffset, 17'h0FFF);
    random_phase(100);
    write_reg(ttt_pkg::RegOffset, 17'h1000);
    random_phase(100);
    write_reg(ttt_pkg::RegFormat, 17'd0);      // no results while format is off
    random_phase(30);
    write_reg(ttt_pkg::RegFormat, 17'd1);
    write_reg(ttt_pkg::RegSeries, 17'd10000);
    write_reg(ttt_pkg::RegOffset, 17'(-435));
    random_phase(650);
  endtask

  // Receiver stall pattern: always ready, random, periodic or mostly ready, redrawn periodically.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= (cycle_count % 7) < 2;
      default: m_axis_tready <= $urandom_range(0, 9) != 0;
    endcase
    if (cycle_count > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("** thermistor_table_temperature_top: FAILED **");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    ttt_pkg::result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.channel = m_axis_tdata[2:0];
      got.signed_code = m_axis_tdata[19:3];
      got.instant_temp = m_axis_tdata[35:20];
      got.filtered_temp = m_axis_tdata[51:36];
      got.range_status = m_axis_tdata[54:52];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (got.channel !== want.channel) begin
          $display("%0t: channel exp %0d got %0d", $time, want.channel, got.channel);
          failed = 1'b1;
        end
        if (got.signed_code !== want.signed_code) begin
          $display("%0t: signed_code exp %0d got %0d", $time, want.signed_code,
                   got.signed_code);
          failed = 1'b1;
        end
        if (got.instant_temp !== want.instant_temp) begin
          $display("%0t: instant_temp exp %0d got %0d", $time, want.instant_temp,
                   got.instant_temp);
          failed = 1'b1;
        end
        if (got.filtered_temp !== want.filtered_temp) begin
          $display("%0t: filtered_temp exp %0d got %0d", $time, want.filtered_temp,
                   got.filtered_temp);
          failed = 1'b1;
        end
        if (got.range_status !== want.range_status) begin
          $display("%0t: range_status exp %0d got %0d", $time, want.range_status,
                   got.range_status);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    stall_mode = 0;
    failed = 1'b0;
    for (int i = 0; i < ttt_pkg::TableEntries; i++) rom_ohms[i] = ttt_pkg::res_rom(7'(i));
    pullup_ohms = 10000;
    cal_offset = -435;
    id_format = 1'b1;
    foreach (ema_store[i]) ema_store[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fault_and_caps();
    test_dropped_channels();
    test_table_points();
    test_register_sweep();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && expected_results.size() == 0)
      $display("** thermistor_table_temperature_top: PASSED **");
    else
      $display("** thermistor_table_temperature_top: FAILED **");
    $finish;
  end
endmodule
